// ===== hdl/breakpoint_table_unit_defines.svh =====
// Assertion macros used by the breakpoint table engine RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef BREAKPOINT_TABLE_UNIT_DEFINES_SVH
`define BREAKPOINT_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define BPT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("breakpoint table assertion failed");

`define BPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("breakpoint table assertion failed");

`else

`define BPT_ASSERT_IMP(lbl, ante, cons)

`define BPT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/bpt_pkg.sv =====
`timescale 1ns / 1ps

package bpt_pkg;

    localparam logic [2:0] CMD_INSERT      = 3'd0;
    localparam logic [2:0] CMD_REMOVE_ID   = 3'd1;
    localparam logic [2:0] CMD_REMOVE_ADDR = 3'd2;
    localparam logic [2:0] CMD_CHECK       = 3'd3;
    localparam logic [2:0] CMD_READ        = 3'd4;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [7:0]  ident;
        logic [31:0] addr;
        logic [31:0] hits;
        logic [1:0]  access;
        logic [1:0]  kind;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [1:0]  status;
        logic        stop;
        logic [7:0]  id;
        logic [31:0] addr;
        logic [31:0] hits;
        logic [1:0]  access;
        logic [1:0]  kind;
    } result_t;

endpackage

// ===== hdl/breakpoint_table_unit.sv =====
`timescale 1ns / 1ps
// Breakpoint table: one command in, one result out.
// Input channel: in_valid / in_stall with command, address, access_kind,
// address_kind, bp_id and slot; a transfer happens when in_valid is high and
// in_stall is low. Output channel: out_valid / out_stall with status, stop,
// entry_id, entry_address, entry_hits, entry_access and entry_kind.
// Configuration: cfg_valid / cfg_ready carrying pc_offset; cfg_ready is
// always high, and pc_offset should only change while the table is idle.
// Entries live in one single-port-read table memory, one entry per word.
// Insert, unknown commands and early misses load the output register with the
// transfer; read slot first reads the memory word, then loads that register.
// Check and both removes walk the memory one entry per cycle from slot 0 while
// the output register is free; at most the used count, up to TABLE_DEPTH.
// One command is in flight at a time; the next is taken once the result is
// in the output register and that register can be refilled.
// Reset empties the table at once through the used count; no clearing pass.
// A result held by out_stall pauses the table walk and blocks new transfers.

module breakpoint_table_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  pc_offset,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [31:0] address,
    input  logic [1:0]  access_kind,
    input  logic [1:0]  address_kind,
    input  logic [7:0]  bp_id,
    input  logic [5:0]  slot,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        stop,
    output logic [7:0]  entry_id,
    output logic [31:0] entry_address,
    output logic [31:0] entry_hits,
    output logic [1:0]  entry_access,
    output logic [1:0]  entry_kind
);

    import bpt_pkg::*;

    logic [3:0] pc_offset_reg, pc_offset_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_res_reg;
    result_t    res;
    logic       res_valid;
    logic       out_free;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    bpt_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .address      (address),
        .access_kind  (access_kind),
        .address_kind (address_kind),
        .bp_id        (bp_id),
        .slot         (slot),
        .pc_offset    (pc_offset_reg),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .res          (res)
    );

    always_comb
    begin
        pc_offset_next = (cfg_valid && cfg_ready) ? pc_offset : pc_offset_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_offset_reg <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_offset_reg <= pc_offset_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_res_reg.status;
    assign stop          = out_res_reg.stop;
    assign entry_id      = out_res_reg.id;
    assign entry_address = out_res_reg.addr;
    assign entry_hits    = out_res_reg.hits;
    assign entry_access  = out_res_reg.access;
    assign entry_kind    = out_res_reg.kind;

endmodule

// ===== hdl/bpt_ram.sv =====
`timescale 1ns / 1ps

module bpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/bpt_engine.sv =====
`timescale 1ns / 1ps
`include "breakpoint_table_unit_defines.svh"

module bpt_engine #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [2:0]       command,
    input  logic [31:0]      address,
    input  logic [1:0]       access_kind,
    input  logic [1:0]       address_kind,
    input  logic [7:0]       bp_id,
    input  logic [5:0]       slot,
    input  logic [3:0]       pc_offset,
    input  logic             out_free,
    output logic             res_valid,
    output bpt_pkg::result_t res
);

    import bpt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [7:0] DEPTH_C = 8'(TABLE_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  issue_reg, issue_next;
    logic [7:0]  cmp_idx_reg, cmp_idx_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [31:0] key_reg, key_next;
    logic [7:0]  id_reg, id_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    entry_t      rd_entry;
    entry_t      wr_entry;
    logic        accept;
    logic        id_hit;
    logic        addr_hit;
    logic        match;
    logic [31:0] hits_inc;
    logic [7:0]  new_id;
    logic [7:0]  slot_ext;
    logic [7:0]  last_idx;

    bpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = entry_t'(ram_rdata);
    assign ram_wdata = wr_entry;

    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;

    assign id_hit   = (rd_entry.ident == id_reg);
    assign addr_hit = (rd_entry.ident != 8'd0) && (rd_entry.addr == key_reg);
    assign match    = (cmd_reg == CMD_REMOVE_ID) ? id_hit : addr_hit;
    assign hits_inc = rd_entry.hits + 32'd1;
    assign new_id   = count_reg + 8'd1;
    assign slot_ext = {2'b00, slot};
    assign last_idx = count_reg - 8'd1;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        issue_next   = issue_reg;
        cmp_idx_next = cmp_idx_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        id_next      = id_reg;
        res_valid    = 1'b0;
        res          = '0;
        res.status   = STATUS_NOT_FOUND;
        ram_we       = 1'b0;
        ram_waddr    = cmp_idx_reg[IDX_W-1:0];
        wr_entry     = rd_entry;
        ram_re       = 1'b0;
        ram_raddr    = issue_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = command;
                    id_next  = bp_id;
                    key_next = (command == CMD_CHECK) ? address - {28'd0, pc_offset}
                                                      : address;
                    case (command)
                        CMD_INSERT:
                        begin
                            res_valid = 1'b1;
                            if (count_reg >= DEPTH_C)
                            begin
                                res.status = STATUS_FULL;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                ram_waddr       = count_reg[IDX_W-1:0];
                                wr_entry.ident  = new_id;
                                wr_entry.addr   = address;
                                wr_entry.hits   = 32'd0;
                                wr_entry.access = access_kind;
                                wr_entry.kind   = address_kind;
                                count_next      = new_id;
                                res.status      = STATUS_OK;
                                res.id          = new_id;
                            end
                        end
                        CMD_REMOVE_ID, CMD_REMOVE_ADDR, CMD_CHECK:
                        begin
                            if (count_reg == 8'd0 ||
                                (command == CMD_REMOVE_ID && bp_id == 8'd0))
                            begin
                                res_valid = 1'b1;
                            end
                            else
                            begin
                                ram_re       = 1'b1;
                                ram_raddr    = '0;
                                cmp_idx_next = 8'd0;
                                issue_next   = 8'd1;
                                state_next   = S_SCAN;
                            end
                        end
                        CMD_READ:
                        begin
                            if (slot_ext < count_reg)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = slot_ext[IDX_W-1:0];
                                state_next = S_READ;
                            end
                            else
                            begin
                                res_valid = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (out_free)
                begin
                    ram_re       = 1'b1;
                    cmp_idx_next = issue_reg;
                    issue_next   = issue_reg + 8'd1;
                    if (match)
                    begin
                        ram_we     = 1'b1;
                        res_valid  = 1'b1;
                        res.status = STATUS_OK;
                        state_next = S_IDLE;
                        if (cmd_reg == CMD_CHECK)
                        begin
                            wr_entry.hits = hits_inc;
                            res.stop      = 1'b1;
                            res.id        = rd_entry.ident;
                            res.addr      = rd_entry.addr;
                            res.hits      = hits_inc;
                        end
                        else
                        begin
                            wr_entry.ident = 8'd0;
                            wr_entry.hits  = 32'd0;
                        end
                    end
                    else if (cmp_idx_reg == last_idx)
                    begin
                        res_valid  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                    if (rd_entry.ident != 8'd0)
                    begin
                        res.status = STATUS_OK;
                        res.id     = rd_entry.ident;
                        res.addr   = rd_entry.addr;
                        res.hits   = rd_entry.hits;
                        res.access = rd_entry.access;
                        res.kind   = rd_entry.kind;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= 8'd0;
            issue_reg   <= 8'd0;
            cmp_idx_reg <= 8'd0;
            cmd_reg     <= CMD_INSERT;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            issue_reg   <= issue_next;
            cmp_idx_reg <= cmp_idx_next;
            cmd_reg     <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        id_reg  <= id_next;
    end

    `BPT_ASSERT_IMP(a_res_needs_room, res_valid, out_free)
    `BPT_ASSERT_IMP(a_count_bounded, 1'b1, count_reg <= DEPTH_C)
    `BPT_ASSERT_IMP(a_scan_in_range, state_reg == S_SCAN, cmp_idx_reg < count_reg)
    `BPT_ASSERT_NEXT(a_insert_grows,
        accept && command == CMD_INSERT && count_reg < DEPTH_C,
        count_reg == $past(count_reg) + 8'd1)

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import bpt_pkg::*;

    localparam int TBL_DEPTH   = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_AFTER  = 40;
    localparam int HOLD_LEN    = 300;
    localparam int DRAIN_WAIT  = 80;
    localparam int PHASE_ITEMS = 100;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] addr;
        logic [1:0]  acc;
        logic [1:0]  kind;
        logic [7:0]  id;
        logic [5:0]  slot_no;
    } bp_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_offset = 4'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  command = 3'd0;
    logic [31:0] address = 32'd0;
    logic [1:0]  access_kind = 2'd0;
    logic [1:0]  address_kind = 2'd0;
    logic [7:0]  bp_id = 8'd0;
    logic [5:0]  slot = 6'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic        stop;
    logic [7:0]  entry_id;
    logic [31:0] entry_address;
    logic [31:0] entry_hits;
    logic [1:0]  entry_access;
    logic [1:0]  entry_kind;

    bp_cmd_t     cmd_backlog[$];
    result_t     pending_answers[$];
    logic [31:0] addr_pool[$];
    int          queued_total = 0;
    int          accepted_count = 0;
    int          results_checked = 0;
    int          inserts_queued = 0;
    int          mismatch_count = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          cycle_count = 0;
    bit          no_idle = 1'b0;
    bit          long_hold_done = 1'b0;
    bp_cmd_t     seen_cmd;
    bp_cmd_t     next_cmd;
    result_t     want;

    logic [3:0]  offset_shadow = 4'd0;
    int          used_slots = 0;
    logic [7:0]  tbl_ident[TBL_DEPTH];
    logic [31:0] tbl_addr[TBL_DEPTH];
    logic [31:0] tbl_hits[TBL_DEPTH];
    logic [1:0]  tbl_access[TBL_DEPTH];
    logic [1:0]  tbl_kind[TBL_DEPTH];

    breakpoint_table_unit #(
        .TABLE_DEPTH(TBL_DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .pc_offset    (cfg_offset),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .address      (address),
        .access_kind  (access_kind),
        .address_kind (address_kind),
        .bp_id        (bp_id),
        .slot         (slot),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .stop         (stop),
        .entry_id     (entry_id),
        .entry_address(entry_address),
        .entry_hits   (entry_hits),
        .entry_access (entry_access),
        .entry_kind   (entry_kind)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            tbl_ident[i]  = 8'd0;
            tbl_addr[i]   = 32'd0;
            tbl_hits[i]   = 32'd0;
            tbl_access[i] = 2'd0;
            tbl_kind[i]   = 2'd0;
        end
    end

    function automatic int find_by_addr(logic [31:0] a);
        int k;
        k = -1;
        for (int i = 0; i < used_slots && i < TBL_DEPTH; i++)
            if (k < 0 && tbl_ident[i] != 8'd0 && tbl_addr[i] == a)
                k = i;
        return k;
    endfunction

    function automatic int find_by_id(logic [7:0] id);
        int k;
        k = -1;
        if (id != 8'd0)
            for (int i = 0; i < used_slots && i < TBL_DEPTH; i++)
                if (k < 0 && tbl_ident[i] == id)
                    k = i;
        return k;
    endfunction

    function automatic result_t table_answer(bp_cmd_t c);
        result_t r;
        int      k;
        int      s;
        r = '0;
        r.status = STATUS_NOT_FOUND;
        case (c.op)
            CMD_INSERT:
            begin
                if (used_slots >= TBL_DEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    s = used_slots;
                    tbl_addr[s]   = c.addr;
                    tbl_access[s] = c.acc;
                    tbl_kind[s]   = c.kind;
                    used_slots    = used_slots + 1;
                    tbl_ident[s]  = 8'(used_slots);
                    r.status = STATUS_OK;
                    r.id     = tbl_ident[s];
                end
            end
            CMD_REMOVE_ID, CMD_REMOVE_ADDR:
            begin
                k = (c.op == CMD_REMOVE_ID) ? find_by_id(c.id) : find_by_addr(c.addr);
                if (k >= 0)
                begin
                    tbl_ident[k] = 8'd0;
                    tbl_hits[k]  = 32'd0;
                    r.status = STATUS_OK;
                end
            end
            CMD_CHECK:
            begin
                k = find_by_addr(c.addr - 32'(offset_shadow));
                if (k >= 0)
                begin
                    tbl_hits[k] = tbl_hits[k] + 32'd1;
                    r.status = STATUS_OK;
                    r.stop   = 1'b1;
                    r.id     = tbl_ident[k];
                    r.addr   = tbl_addr[k];
                    r.hits   = tbl_hits[k];
                end
            end
            CMD_READ:
            begin
                if (int'(c.slot_no) < used_slots && tbl_ident[c.slot_no] != 8'd0)
                begin
                    r.status = STATUS_OK;
                    r.id     = tbl_ident[c.slot_no];
                    r.addr   = tbl_addr[c.slot_no];
                    r.hits   = tbl_hits[c.slot_no];
                    r.access = tbl_access[c.slot_no];
                    r.kind   = tbl_kind[c.slot_no];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want_v, got_v);
            mismatch_count++;
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // drive the command channel; hold the payload while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            command      <= 3'd0;
            address      <= 32'd0;
            access_kind  <= 2'd0;
            address_kind <= 2'd0;
            bp_id        <= 8'd0;
            slot         <= 6'd0;
            gap_left     <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (cmd_backlog.size() > 0)
            begin
                next_cmd = cmd_backlog.pop_front();
                command      <= next_cmd.op;
                address      <= next_cmd.addr;
                access_kind  <= next_cmd.acc;
                address_kind <= next_cmd.kind;
                bp_id        <= next_cmd.id;
                slot         <= next_cmd.slot_no;
                in_valid     <= 1'b1;
                gap_left     <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (!long_hold_done && results_checked >= HOLD_AFTER)
        begin
            long_hold_done <= 1'b1;
            stall_left     <= HOLD_LEN;
            out_stall      <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (no_idle || $urandom_range(0, 99) < 65)
            out_stall <= 1'b0;
        else
        begin
            out_stall  <= 1'b1;
            stall_left <= ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2)
                                                      : $urandom_range(10, 40);
        end
    end

    // check each result transfer, then predict the command transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_answers.size() == 0)
                begin
                    $display("%0t: result expected none actual status %0h id %0h",
                             $time, status, entry_id);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("stop", 32'(want.stop), 32'(stop));
                    check_field("entry_id", 32'(want.id), 32'(entry_id));
                    check_field("entry_address", want.addr, entry_address);
                    check_field("entry_hits", want.hits, entry_hits);
                    check_field("entry_access", 32'(want.access), 32'(entry_access));
                    check_field("entry_kind", 32'(want.kind), 32'(entry_kind));
                end
                results_checked <= results_checked + 1;
            end
            if (in_valid && !in_stall)
            begin
                seen_cmd.op      = command;
                seen_cmd.addr    = address;
                seen_cmd.acc     = access_kind;
                seen_cmd.kind    = address_kind;
                seen_cmd.id      = bp_id;
                seen_cmd.slot_no = slot;
                pending_answers.push_back(table_answer(seen_cmd));
                accepted_count <= accepted_count + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic bp_cmd_t make_cmd(logic [2:0] op, logic [31:0] addr, logic [1:0] acc,
                                         logic [1:0] kind, logic [7:0] id, logic [5:0] sl);
        bp_cmd_t c;
        c.op      = op;
        c.addr    = addr;
        c.acc     = acc;
        c.kind    = kind;
        c.id      = id;
        c.slot_no = sl;
        return c;
    endfunction

    task automatic queue_cmd(input bp_cmd_t c);
        if (c.op == CMD_INSERT)
        begin
            inserts_queued++;
            addr_pool.push_back(c.addr);
        end
        cmd_backlog.push_back(c);
        queued_total++;
    endtask

    function automatic logic [31:0] pool_addr();
        if (addr_pool.size() == 0)
            return $urandom;
        return addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    endfunction

    task automatic queue_random(input int count, input logic [3:0] off);
        bp_cmd_t c;
        int      r;
        for (int n = 0; n < count; n++)
        begin
            c = make_cmd(CMD_INSERT, $urandom, 2'($urandom), 2'($urandom),
                         8'($urandom), 6'($urandom));
            r = $urandom_range(0, 99);
            if (r < 20)
            begin
                c.op = CMD_INSERT;
                if ($urandom_range(0, 4) == 0)
                    c.addr = pool_addr();
            end
            else if (r < 30)
            begin
                c.op = CMD_REMOVE_ID;
                r = $urandom_range(0, 99);
                if (r < 70)
                    c.id = 8'($urandom_range(1, (inserts_queued > 0) ? inserts_queued : 1));
                else if (r < 85)
                    c.id = 8'd0;
            end
            else if (r < 37)
            begin
                c.op = CMD_REMOVE_ADDR;
                if ($urandom_range(0, 9) < 7)
                    c.addr = pool_addr();
            end
            else if (r < 75)
            begin
                c.op = CMD_CHECK;
                if ($urandom_range(0, 3) != 0)
                    c.addr = pool_addr() + 32'(off);
            end
            else if (r < 95)
            begin
                c.op = CMD_READ;
                if ($urandom_range(0, 9) < 7 && inserts_queued > 0)
                    c.slot_no = 6'($urandom_range(0, (inserts_queued < TBL_DEPTH)
                                                     ? inserts_queued - 1 : TBL_DEPTH - 1));
            end
            else
                c.op = 3'($urandom_range(5, 7));
            queue_cmd(c);
        end
    endtask

    task automatic wait_idle();
        while (accepted_count != queued_total || results_checked != accepted_count)
            @(posedge clk);
    endtask

    task automatic write_offset(input logic [3:0] v);
        cfg_valid  <= 1'b1;
        cfg_offset <= v;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        offset_shadow = v;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [3:0] phase_offset[4];
        phase_offset[0] = 4'd8;
        phase_offset[1] = 4'd15;
        phase_offset[2] = 4'($urandom_range(1, 14));
        phase_offset[3] = 4'd0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_offset(4'd0);

        queue_cmd(make_cmd(CMD_READ, 32'd0, 2'd0, 2'd0, 8'd0, 6'd0));
        queue_cmd(make_cmd(CMD_REMOVE_ID, 32'd0, 2'd0, 2'd0, 8'd0, 6'd0));
        queue_cmd(make_cmd(CMD_REMOVE_ID, 32'd0, 2'd0, 2'd0, 8'd255, 6'd0));
        queue_cmd(make_cmd(CMD_REMOVE_ADDR, 32'hFFFF_FFFF, 2'd3, 2'd3, 8'd5, 6'd63));
        queue_cmd(make_cmd(CMD_CHECK, 32'd0, 2'd0, 2'd0, 8'd0, 6'd0));
        queue_cmd(make_cmd(3'd5, $urandom, 2'd3, 2'd3, 8'd255, 6'd63));
        queue_cmd(make_cmd(3'd6, $urandom, 2'd1, 2'd2, 8'd1, 6'd1));
        queue_cmd(make_cmd(3'd7, $urandom, 2'd2, 2'd1, 8'd2, 6'd2));
        queue_cmd(make_cmd(CMD_INSERT, 32'd0, 2'd0, 2'd0, 8'd0, 6'd0));
        queue_cmd(make_cmd(CMD_INSERT, 32'hFFFF_FFFF, 2'd3, 2'd3, 8'd255, 6'd63));
        queue_cmd(make_cmd(CMD_INSERT, 32'h0000_1000, 2'd1, 2'd2, 8'd0, 6'd0));
        queue_cmd(make_cmd(CMD_INSERT, 32'd0, 2'd2, 2'd1, 8'd0, 6'd0));
        queue_cmd(make_cmd(CMD_CHECK, 32'd0, 2'd0, 2'd0, 8'd0, 6'd0));
        queue_cmd(make_cmd(CMD_CHECK, 32'd0, 2'd0, 2'd0, 8'd0, 6'd0));
        queue_cmd(make_cmd(CMD_READ, 32'd0, 2'd0, 2'd0, 8'd0, 6'd0));
        queue_cmd(make_cmd(CMD_READ, 32'd0, 2'd0, 2'd0, 8'd0, 6'd3));
        queue_cmd(make_cmd(CMD_READ, 32'd0, 2'd0, 2'd0, 8'd0, 6'd63));
        queue_cmd(make_cmd(CMD_REMOVE_ID, 32'd0, 2'd0, 2'd0, 8'd1, 6'd0));
        queue_cmd(make_cmd(CMD_CHECK, 32'd0, 2'd0, 2'd0, 8'd0, 6'd0));
        queue_cmd(make_cmd(CMD_REMOVE_ADDR, 32'd0, 2'd0, 2'd0, 8'd0, 6'd0));
        queue_cmd(make_cmd(CMD_CHECK, 32'd0, 2'd0, 2'd0, 8'd0, 6'd0));
        queue_cmd(make_cmd(CMD_READ, 32'd0, 2'd0, 2'd0, 8'd0, 6'd0));
        queue_cmd(make_cmd(CMD_REMOVE_ID, 32'd0, 2'd0, 2'd0, 8'd1, 6'd0));
        queue_cmd(make_cmd(CMD_INSERT, 32'h8000_0000, 2'd1, 2'd1, 8'd0, 6'd0));
        queue_cmd(make_cmd(CMD_CHECK, 32'hFFFF_FFFF, 2'd0, 2'd0, 8'd0, 6'd0));
        wait_idle();

        // pc below the offset wraps around to the top of the address space
        write_offset(4'd15);
        queue_cmd(make_cmd(CMD_CHECK, 32'h0000_100F, 2'd0, 2'd0, 8'd0, 6'd0));
        queue_cmd(make_cmd(CMD_CHECK, 32'h0000_000E, 2'd0, 2'd0, 8'd0, 6'd0));
        queue_cmd(make_cmd(CMD_CHECK, 32'h0000_000F, 2'd0, 2'd0, 8'd0, 6'd0));
        wait_idle();

        for (int p = 0; p < 4; p++)
        begin
            write_offset(phase_offset[p]);
            no_idle = (p == 2);
            queue_random(PHASE_ITEMS, phase_offset[p]);
            wait_idle();
        end
        no_idle = 1'b0;

        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
